FILE: design/bun_pkg.sv
// ----------------------------------------------------------------------------
// bun_pkg
// Shared types and constants for the boundary unit normal pipeline.
// ----------------------------------------------------------------------------
package bun_pkg;

  // dimension register codes
  localparam logic [1:0] DIM_EDGE  = 2'd2;
  localparam logic [1:0] DIM_RESET = 2'd3;

  // control that travels with each item through the normalization stages
  typedef struct packed {
    logic valid;
    logic degen;
  } pipe_ctl_t;

endpackage

FILE: design/bun_cross.sv
// ----------------------------------------------------------------------------
// bun_cross
// Edge differences, six signed products and the raw normal (three stages).
// ----------------------------------------------------------------------------
module bun_cross #(
  parameter int COORD_WIDTH = 32,
  localparam int DW = COORD_WIDTH + 1,
  localparam int PW = 2 * DW,
  localparam int NW = PW + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic                          mode_edge,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] a_z,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] b_z,
  input  logic signed [COORD_WIDTH-1:0] c_x,
  input  logic signed [COORD_WIDTH-1:0] c_y,
  input  logic signed [COORD_WIDTH-1:0] c_z,
  output logic                          valid_o,
  output logic signed [NW-1:0]          n_o [3]
);

  logic                 va_r, vb_r, vc_r;
  logic signed [DW-1:0] ax_nxt, ay_nxt, az_nxt, bx_nxt, by_nxt, bz_nxt;
  logic signed [DW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [PW-1:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [NW-1:0] n_nxt [3];
  logic signed [NW-1:0] n_r [3];

  // Edge mode: ax = dx, ay = dy, bz = 1, rest zero, so the cross
  // product collapses to (dy, -dx, 0).
  always_comb begin
    ax_nxt = DW'(b_x) - DW'(a_x);
    ay_nxt = DW'(b_y) - DW'(a_y);
    if (mode_edge) begin
      az_nxt = '0;
      bx_nxt = '0;
      by_nxt = '0;
      bz_nxt = DW'(1);
    end else begin
      az_nxt = DW'(b_z) - DW'(a_z);
      bx_nxt = DW'(c_x) - DW'(a_x);
      by_nxt = DW'(c_y) - DW'(a_y);
      bz_nxt = DW'(c_z) - DW'(a_z);
    end
  end

  always_comb begin
    n_nxt[0] = NW'(p_yz_r) - NW'(p_zy_r);
    n_nxt[1] = NW'(p_zx_r) - NW'(p_xz_r);
    n_nxt[2] = NW'(p_xy_r) - NW'(p_yx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      az_r   <= az_nxt;
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
      bz_r   <= bz_nxt;
      p_yz_r <= ay_r * bz_r;
      p_zy_r <= az_r * by_r;
      p_zx_r <= az_r * bx_r;
      p_xz_r <= ax_r * bz_r;
      p_xy_r <= ax_r * by_r;
      p_yx_r <= ay_r * bx_r;
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= n_nxt[k];
      end
    end
  end

  assign valid_o = vc_r;
  assign n_o     = n_r;

endmodule

FILE: design/bun_square.sv
// ----------------------------------------------------------------------------
// bun_square
// Magnitudes, split squares, squared length and the digit loop seed
// (five stages).
// ----------------------------------------------------------------------------
module bun_square
  import bun_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 30,
  localparam int DW  = COORD_WIDTH + 1,
  localparam int NW  = 2 * DW + 1,
  localparam int MW  = 2 * DW,
  localparam int SQW = 2 * MW,
  localparam int SW  = SQW + 2,
  localparam int RW  = SQW + 2 * OUT_FRAC_BITS + 7,
  localparam int PWD = SW + OUT_FRAC_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic signed [NW-1:0]  n_i [3],
  output pipe_ctl_t             ctl_o,
  output logic [2:0]            neg_o,
  output logic [SW-1:0]         s_o,
  output logic signed [RW-1:0]  r_o [3],
  output logic signed [PWD-1:0] p_o [3]
);

  logic                 vc_r, vd_r, ve_r, vf_r;
  pipe_ctl_t            ctl_r;
  logic [2:0]           neg_c_r, neg_d_r, neg_e_r, neg_f_r, neg_g_r;
  logic signed [NW-1:0] abs_nxt [3];
  logic [MW-1:0]        mag_r [3];
  logic [MW-1:0]        hh_r [3];
  logic [MW-1:0]        hl_r [3];
  logic [MW-1:0]        ll_r [3];
  logic [SQW-1:0]       sq_nxt [3];
  logic [SQW-1:0]       sq_e_r [3];
  logic [SQW-1:0]       sq_f_r [3];
  logic [SW-1:0]        s_nxt, s_f_r, s_g_r;
  logic signed [RW-1:0]  r_nxt [3];
  logic signed [RW-1:0]  r_r [3];
  logic signed [PWD-1:0] p_nxt, p_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_nxt[k] = n_i[k][NW-1] ? -n_i[k] : n_i[k];
      sq_nxt[k]  = (SQW'(hh_r[k]) << (2 * DW)) + (SQW'(hl_r[k]) << (DW + 1))
                   + SQW'(ll_r[k]);
    end
    s_nxt = SW'(sq_e_r[0]) + SW'(sq_e_r[1]) + SW'(sq_e_r[2]);
    // seed: residual = |n_i|^2 * 4^(F+1) - s, running product = -s
    for (int k = 0; k < 3; k++) begin
      r_nxt[k] = $signed(RW'(sq_f_r[k]) << (2 * OUT_FRAC_BITS + 2))
                 - $signed(RW'(s_f_r));
    end
    p_nxt = -$signed(PWD'(s_f_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= 1'b0;
      vd_r  <= 1'b0;
      ve_r  <= 1'b0;
      vf_r  <= 1'b0;
      ctl_r <= '0;
    end else if (en) begin
      vc_r        <= valid_i;
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      vf_r        <= ve_r;
      ctl_r.valid <= vf_r;
      ctl_r.degen <= (s_f_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg_c_r[k] <= n_i[k][NW-1];
        mag_r[k]   <= abs_nxt[k][MW-1:0];
        hh_r[k]    <= mag_r[k][MW-1:DW] * mag_r[k][MW-1:DW];
        hl_r[k]    <= mag_r[k][MW-1:DW] * mag_r[k][DW-1:0];
        ll_r[k]    <= mag_r[k][DW-1:0] * mag_r[k][DW-1:0];
        sq_e_r[k]  <= sq_nxt[k];
        sq_f_r[k]  <= sq_e_r[k];
        r_r[k]     <= r_nxt[k];
      end
      neg_d_r <= neg_c_r;
      neg_e_r <= neg_d_r;
      neg_f_r <= neg_e_r;
      neg_g_r <= neg_f_r;
      s_f_r   <= s_nxt;
      s_g_r   <= s_f_r;
      p_r     <= p_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign neg_o = neg_g_r;
  assign s_o   = s_g_r;
  assign r_o   = r_r;
  assign p_o[0] = p_r;
  assign p_o[1] = p_r;
  assign p_o[2] = p_r;

endmodule

FILE: design/bun_digit.sv
// ----------------------------------------------------------------------------
// bun_digit
// One quotient bit of the rounded |n_i| / |n| for all three components.
// ----------------------------------------------------------------------------
module bun_digit
  import bun_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 30,
  parameter int BIT           = 0,
  localparam int DW  = COORD_WIDTH + 1,
  localparam int SQW = 4 * DW,
  localparam int SW  = SQW + 2,
  localparam int RW  = SQW + 2 * OUT_FRAC_BITS + 7,
  localparam int PWD = SW + OUT_FRAC_BITS + 3,
  localparam int QW  = OUT_FRAC_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  pipe_ctl_t             ctl_i,
  input  logic [2:0]            neg_i,
  input  logic [SW-1:0]         s_i,
  input  logic signed [RW-1:0]  r_i [3],
  input  logic signed [PWD-1:0] p_i [3],
  input  logic [QW-1:0]         q_i [3],
  output pipe_ctl_t             ctl_o,
  output logic [2:0]            neg_o,
  output logic [SW-1:0]         s_o,
  output logic signed [RW-1:0]  r_o [3],
  output logic signed [PWD-1:0] p_o [3],
  output logic [QW-1:0]         q_o [3]
);

  pipe_ctl_t             ctl_r;
  logic [2:0]            neg_r;
  logic [SW-1:0]         s_r;
  logic signed [RW-1:0]  s_sh;
  logic signed [RW-1:0]  d [3];
  logic [2:0]            take;
  logic signed [RW-1:0]  r_nxt [3];
  logic signed [PWD-1:0] p_nxt [3];
  logic [QW-1:0]         q_nxt [3];
  logic signed [RW-1:0]  r_r [3];
  logic signed [PWD-1:0] p_r [3];
  logic [QW-1:0]         q_r [3];

  // Trial q + 2^BIT raises (2q-1)^2 * s by s*2^(BIT+2)*(2^BIT + 2q - 1);
  // keep the bit when the residual stays non-negative.
  always_comb begin
    s_sh = $signed(RW'(s_i)) <<< (2 * BIT + 2);
    for (int k = 0; k < 3; k++) begin
      d[k]     = r_i[k] - s_sh - (RW'(p_i[k]) <<< (BIT + 2));
      take[k]  = ~d[k][RW-1];
      r_nxt[k] = take[k] ? d[k] : r_i[k];
      p_nxt[k] = take[k] ? p_i[k] + $signed(PWD'(s_i) << (BIT + 1)) : p_i[k];
      q_nxt[k] = q_i[k] | (QW'(take[k]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= neg_i;
      s_r   <= s_i;
      for (int k = 0; k < 3; k++) begin
        r_r[k] <= r_nxt[k];
        p_r[k] <= p_nxt[k];
        q_r[k] <= q_nxt[k];
      end
    end
  end

  assign ctl_o = ctl_r;
  assign neg_o = neg_r;
  assign s_o   = s_r;
  assign r_o   = r_r;
  assign p_o   = p_r;
  assign q_o   = q_r;

endmodule

FILE: design/boundary_unit_normal.sv
// ----------------------------------------------------------------------------
// boundary_unit_normal
// Unit normal of a 2D edge or 3D triangle, Q16.16 in, Q1.30 out.
// ----------------------------------------------------------------------------
// Takes one element per clock unless in_stall is high: three stages form
// the differences, products and raw normal, five form the exact squared
// length, and one stage per output bit (OUT_FRAC_BITS + 1 of them)
// resolves the rounded quotient |n_i| / |n| for all three components at
// once, followed by the output register. A stall on the result side
// freezes the whole pipeline. The coordinate fraction position cancels
// and needs no setting. Write the dimension register only while no
// element is in flight.
module boundary_unit_normal
  import bun_pkg::*;
#(
  parameter int COORD_WIDTH   = 32,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   in_point_a_x,
  input  logic signed [COORD_WIDTH-1:0]   in_point_a_y,
  input  logic signed [COORD_WIDTH-1:0]   in_point_a_z,
  input  logic signed [COORD_WIDTH-1:0]   in_point_b_x,
  input  logic signed [COORD_WIDTH-1:0]   in_point_b_y,
  input  logic signed [COORD_WIDTH-1:0]   in_point_b_z,
  input  logic signed [COORD_WIDTH-1:0]   in_point_c_x,
  input  logic signed [COORD_WIDTH-1:0]   in_point_c_y,
  input  logic signed [COORD_WIDTH-1:0]   in_point_c_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [OUT_FRAC_BITS+1:0] out_normal_x,
  output logic signed [OUT_FRAC_BITS+1:0] out_normal_y,
  output logic signed [OUT_FRAC_BITS+1:0] out_normal_z,
  output logic                            out_degenerate
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int NW  = 2 * DW + 1;
  localparam int SQW = 4 * DW;
  localparam int SW  = SQW + 2;
  localparam int RW  = SQW + 2 * OUT_FRAC_BITS + 7;
  localparam int PWD = SW + OUT_FRAC_BITS + 3;
  localparam int QW  = OUT_FRAC_BITS + 1;
  localparam int OW  = OUT_FRAC_BITS + 2;
  localparam int NST = OUT_FRAC_BITS + 1;

  logic                  en;
  logic [1:0]            dim_r;
  logic                  cross_valid;
  logic signed [NW-1:0]  n_w [3];

  pipe_ctl_t             ctl_w [NST+1];
  logic [2:0]            neg_w [NST+1];
  logic [SW-1:0]         s_w [NST+1];
  logic signed [RW-1:0]  r_w [NST+1][3];
  logic signed [PWD-1:0] p_w [NST+1][3];
  logic [QW-1:0]         q_w [NST+1][3];

  logic                  out_valid_r;
  logic                  degen_r;
  logic signed [OW-1:0]  comp_nxt [3];
  logic signed [OW-1:0]  comp_r [3];

  // advance every stage unless a held result blocks the output
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_valid) begin
      dim_r <= cfg_data;
    end
  end

  bun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (in_valid),
    .mode_edge (dim_r == DIM_EDGE),
    .a_x       (in_point_a_x),
    .a_y       (in_point_a_y),
    .a_z       (in_point_a_z),
    .b_x       (in_point_b_x),
    .b_y       (in_point_b_y),
    .b_z       (in_point_b_z),
    .c_x       (in_point_c_x),
    .c_y       (in_point_c_y),
    .c_z       (in_point_c_z),
    .valid_o   (cross_valid),
    .n_o       (n_w)
  );

  bun_square #(
    .COORD_WIDTH   (COORD_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (cross_valid),
    .n_i     (n_w),
    .ctl_o   (ctl_w[0]),
    .neg_o   (neg_w[0]),
    .s_o     (s_w[0]),
    .r_o     (r_w[0]),
    .p_o     (p_w[0])
  );

  assign q_w[0][0] = '0;
  assign q_w[0][1] = '0;
  assign q_w[0][2] = '0;

  for (genvar j = 0; j < NST; j++) begin : g_digit
    bun_digit #(
      .COORD_WIDTH   (COORD_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .BIT           (OUT_FRAC_BITS - j)
    ) u_digit (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_w[j]),
      .neg_i (neg_w[j]),
      .s_i   (s_w[j]),
      .r_i   (r_w[j]),
      .p_i   (p_w[j]),
      .q_i   (q_w[j]),
      .ctl_o (ctl_w[j+1]),
      .neg_o (neg_w[j+1]),
      .s_o   (s_w[j+1]),
      .r_o   (r_w[j+1]),
      .p_o   (p_w[j+1]),
      .q_o   (q_w[j+1])
    );
  end

  // apply sign; a zero-length normal drops all components to zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (ctl_w[NST].degen) begin
        comp_nxt[k] = '0;
      end else if (neg_w[NST][k]) begin
        comp_nxt[k] = -$signed(OW'(q_w[NST][k]));
      end else begin
        comp_nxt[k] = $signed(OW'(q_w[NST][k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_w[NST].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen_r <= ctl_w[NST].degen;
      for (int k = 0; k < 3; k++) begin
        comp_r[k] <= comp_nxt[k];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = comp_r[0];
  assign out_normal_y   = comp_r[1];
  assign out_normal_z   = comp_r[2];
  assign out_degenerate = degen_r;

endmodule
